### rtl/core/ohm_pkg.sv
// ----------------------------------------------------------------------------
// Ohmmeter package
// Widths, constants, E24 tables and shared types of the ohmmeter block.
// ----------------------------------------------------------------------------
package ohm_pkg;

  localparam int ADC_BITS    = 12;
  localparam int MAX_SAMPLES = 1024;
  localparam int CNT_W       = 11;
  localparam int SUM_W       = 22;
  localparam int KNOWN_W     = 20;
  localparam int SPAN_W      = CNT_W + ADC_BITS;
  localparam int DEN_W       = 22;
  localparam int PROD_W      = KNOWN_W + SUM_W;
  localparam int FRAC_W      = 8;
  localparam int NUM_W       = PROD_W + FRAC_W;
  localparam int QUO_W       = 36;
  localparam int OHMS_W      = 27;
  localparam int MANT_W      = 7;
  localparam int SCALE_W     = 20;
  localparam int BAND_W      = 4;
  localparam int MULT_W      = 3;
  localparam int IDX_W       = 5;
  localparam int E24_COUNT   = 24;
  localparam int DECADES     = 7;
  localparam int MUL_CNT_W   = $clog2(KNOWN_W);
  localparam int DIV_CNT_W   = $clog2(NUM_W);

  localparam logic [KNOWN_W-1:0] KNOWN_RESET = 20'd67000;
  localparam logic [CNT_W-1:0]   SPR_RESET   = 11'd500;
  localparam logic [OHMS_W-1:0]  OHMS_LIMIT  = 27'd100000000;

  typedef enum logic [0:0] {
    CFG_KNOWN_OHMS,
    CFG_SAMPLES_PER_READING
  } cfg_idx_e;

  typedef struct packed {
    logic [OHMS_W-1:0] nearest;
    logic [BAND_W-1:0] first;
    logic [BAND_W-1:0] second;
    logic [MULT_W-1:0] mult;
  } e24_res_t;

  function automatic logic [MANT_W-1:0] e24_mantissa(input logic [IDX_W-1:0] idx);
    logic [MANT_W-1:0] m;
    case (idx)
      5'd0:    m = 7'd10;
      5'd1:    m = 7'd11;
      5'd2:    m = 7'd12;
      5'd3:    m = 7'd13;
      5'd4:    m = 7'd15;
      5'd5:    m = 7'd16;
      5'd6:    m = 7'd18;
      5'd7:    m = 7'd20;
      5'd8:    m = 7'd22;
      5'd9:    m = 7'd24;
      5'd10:   m = 7'd27;
      5'd11:   m = 7'd30;
      5'd12:   m = 7'd33;
      5'd13:   m = 7'd36;
      5'd14:   m = 7'd39;
      5'd15:   m = 7'd43;
      5'd16:   m = 7'd47;
      5'd17:   m = 7'd51;
      5'd18:   m = 7'd56;
      5'd19:   m = 7'd62;
      5'd20:   m = 7'd68;
      5'd21:   m = 7'd75;
      5'd22:   m = 7'd82;
      5'd23:   m = 7'd91;
      default: m = 7'd0;
    endcase
    return m;
  endfunction

  function automatic logic [BAND_W-1:0] e24_tens(input logic [IDX_W-1:0] idx);
    logic [BAND_W-1:0] t;
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6:  t = 4'd1;
      5'd7, 5'd8, 5'd9, 5'd10:                  t = 4'd2;
      5'd11, 5'd12, 5'd13, 5'd14:               t = 4'd3;
      5'd15, 5'd16:                             t = 4'd4;
      5'd17, 5'd18:                             t = 4'd5;
      5'd19, 5'd20:                             t = 4'd6;
      5'd21:                                    t = 4'd7;
      5'd22:                                    t = 4'd8;
      5'd23:                                    t = 4'd9;
      default:                                  t = 4'd0;
    endcase
    return t;
  endfunction

  function automatic logic [BAND_W-1:0] e24_units(input logic [IDX_W-1:0] idx);
    logic [BAND_W-1:0] u;
    case (idx)
      5'd0, 5'd7, 5'd11:           u = 4'd0;
      5'd1, 5'd17, 5'd23:          u = 4'd1;
      5'd2, 5'd8, 5'd19, 5'd22:    u = 4'd2;
      5'd3, 5'd12, 5'd15:          u = 4'd3;
      5'd9:                        u = 4'd4;
      5'd4, 5'd21:                 u = 4'd5;
      5'd5, 5'd13, 5'd18:          u = 4'd6;
      5'd10, 5'd16:                u = 4'd7;
      5'd6, 5'd20:                 u = 4'd8;
      5'd14:                       u = 4'd9;
      default:                     u = 4'd0;
    endcase
    return u;
  endfunction

  function automatic logic [SCALE_W-1:0] decade_scale(input logic [MULT_W-1:0] m);
    logic [SCALE_W-1:0] s;
    case (m)
      3'd0:    s = 20'd1;
      3'd1:    s = 20'd10;
      3'd2:    s = 20'd100;
      3'd3:    s = 20'd1000;
      3'd4:    s = 20'd10000;
      3'd5:    s = 20'd100000;
      3'd6:    s = 20'd1000000;
      default: s = 20'd0;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/ohmmeter_e24_color_bands.sv
// ----------------------------------------------------------------------------
// Ohmmeter with E24 colour bands
// A sample that does not end a reading is taken while the block is idle. The
// last sample of a reading stalls the input through the arithmetic (a 20-step
// multiplier, then a 50-step divider) and an E24 search, so its word appears
// once the output register is free, and the next sample can follow in the
// cycle after that. Reset clears the accumulator and loads known_ohms 67000
// and samples_per_reading 500.
// ----------------------------------------------------------------------------
module ohmmeter_e24_color_bands (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  ohm_pkg::cfg_idx_e            cfg_index_i,
  input  logic [ohm_pkg::KNOWN_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ohm_pkg::ADC_BITS-1:0] adc_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ohm_pkg::ADC_BITS-1:0] average_code_o,
  output logic [ohm_pkg::OHMS_W-1:0]   measured_ohms_o,
  output logic [ohm_pkg::OHMS_W-1:0]   nearest_standard_ohms_o,
  output logic [ohm_pkg::BAND_W-1:0]   first_band_o,
  output logic [ohm_pkg::BAND_W-1:0]   second_band_o,
  output logic [ohm_pkg::MULT_W-1:0]   multiplier_band_o,
  output logic                         over_range_o
);
  import ohm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_SRCH = 3'd5;
  localparam logic [2:0] ST_HOLD = 3'd6;

  localparam int OHMS_WIDE_W = QUO_W + 1 - FRAC_W;

  logic [2:0]         state_q;
  logic [KNOWN_W-1:0] known_q;
  logic [CNT_W-1:0]   spr_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SUM_W-1:0]   fin_sum_q;
  logic [CNT_W-1:0]   fin_cnt_q;
  logic [DEN_W-1:0]   den_q;
  logic               pre_over_q;

  logic               out_valid_q;
  logic [ADC_BITS-1:0] avg_out_q;
  logic [OHMS_W-1:0]  ohms_q;
  logic               over_q;
  logic [OHMS_W-1:0]  ohms_out_q;
  logic               over_out_q;
  e24_res_t           e24_out_q;

  logic [CNT_W-1:0]   reading_len;
  logic [CNT_W-1:0]   cnt_inc;
  logic [SUM_W-1:0]   sum_inc;
  logic               in_acc;
  logic               completes;
  logic [SPAN_W-1:0]  span;
  logic [SPAN_W-1:0]  den_full;
  logic               pre_over;
  logic [NUM_W-1:0]   avg_num;
  logic [DEN_W-1:0]   avg_den;

  logic               mul_start;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_prod;
  logic               res_start;
  logic               res_done;
  logic [QUO_W-1:0]   res_quo;
  logic               res_ovf;
  logic               avg_done;
  logic [QUO_W-1:0]   avg_quo;
  logic               avg_ovf;
  logic               e24_start;
  logic               e24_done;
  e24_res_t           e24_res;

  logic [QUO_W:0]       q_round;
  logic [OHMS_WIDE_W-1:0] ohms_wide;
  logic                 sat;
  logic [QUO_W-1:0]     search_q;
  logic                 out_load;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != ST_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    if (spr_q == '0) begin
      reading_len = CNT_W'(1);
    end else if (spr_q > CNT_W'(MAX_SAMPLES)) begin
      reading_len = CNT_W'(MAX_SAMPLES);
    end else begin
      reading_len = spr_q;
    end
  end

  assign cnt_inc   = cnt_q + 1'b1;
  assign sum_inc   = sum_q + SUM_W'(adc_sample_i);
  assign completes = cnt_inc >= reading_len;

  assign span     = {fin_cnt_q, ADC_BITS'(0)} - SPAN_W'(fin_cnt_q);
  assign pre_over = SPAN_W'(fin_sum_q) >= span;
  assign den_full = span - SPAN_W'(fin_sum_q);
  assign avg_num  = NUM_W'({fin_sum_q, 1'b0}) + NUM_W'(fin_cnt_q);
  assign avg_den  = DEN_W'({fin_cnt_q, 1'b0});

  assign mul_start = state_q == ST_PREP;
  assign res_start = (state_q == ST_MUL) && mul_done;
  assign e24_start = state_q == ST_FIN;

  assign q_round   = {1'b0, res_quo} + (QUO_W + 1)'(1 << (FRAC_W - 1));
  assign ohms_wide = q_round[QUO_W:FRAC_W];
  assign sat       = pre_over_q || res_ovf || (ohms_wide > OHMS_WIDE_W'(OHMS_LIMIT));
  assign search_q  = sat ? QUO_W'({OHMS_LIMIT, FRAC_W'(0)}) : res_quo;

  assign out_load = (state_q == ST_HOLD) && (!out_valid_q || !out_stall_i);

  ohm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (known_q),
    .b_i     (fin_sum_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ohm_div u_res_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (res_start),
    .num_i   ({mul_prod, FRAC_W'(0)}),
    .den_i   (den_q),
    .done_o  (res_done),
    .quo_o   (res_quo),
    .ovf_o   (res_ovf)
  );

  ohm_div u_avg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .num_i   (avg_num),
    .den_i   (avg_den),
    .done_o  (avg_done),
    .quo_o   (avg_quo),
    .ovf_o   (avg_ovf)
  );

  ohm_e24 u_e24 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (e24_start),
    .q_i     (search_q),
    .done_o  (e24_done),
    .res_o   (e24_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= KNOWN_RESET;
      spr_q   <= SPR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KNOWN_OHMS:          known_q <= cfg_data_i;
        CFG_SAMPLES_PER_READING: spr_q   <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (completes) begin
              sum_q   <= '0;
              cnt_q   <= '0;
              state_q <= ST_PREP;
            end else begin
              sum_q <= sum_inc;
              cnt_q <= cnt_inc;
            end
          end
        end
        ST_PREP: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (res_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_q <= ST_SRCH;
        end
        ST_SRCH: begin
          if (e24_done) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && completes) begin
      fin_sum_q <= sum_inc;
      fin_cnt_q <= cnt_inc;
    end
    if (state_q == ST_PREP) begin
      den_q      <= den_full[DEN_W-1:0];
      pre_over_q <= pre_over;
    end
    if (state_q == ST_FIN) begin
      ohms_q <= sat ? OHMS_LIMIT : ohms_wide[OHMS_W-1:0];
      over_q <= sat;
    end
    if (out_load) begin
      avg_out_q  <= avg_quo[ADC_BITS-1:0];
      ohms_out_q <= ohms_q;
      over_out_q <= over_q;
      e24_out_q  <= e24_res;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign average_code_o          = avg_out_q;
  assign measured_ohms_o         = ohms_out_q;
  assign nearest_standard_ohms_o = e24_out_q.nearest;
  assign first_band_o            = e24_out_q.first;
  assign second_band_o           = e24_out_q.second;
  assign multiplier_band_o       = e24_out_q.mult;
  assign over_range_o            = over_out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(MAX_SAMPLES))
    else $error("sample count reached the maximum reading length");

  a_avg_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_done |-> !avg_ovf && (avg_quo[QUO_W-1:ADC_BITS] == '0))
    else $error("average code overflowed its width");

  a_over_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && over_range_o |-> measured_ohms_o == OHMS_LIMIT)
    else $error("over range flagged without saturated resistance");

  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MUL)
    else $error("multiplier finished outside the multiply phase");

  a_e24_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e24_done |-> state_q == ST_SRCH)
    else $error("E24 search finished outside the search phase");

endmodule

### rtl/core/ohm_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add multiplier taking one bit of the reference value per cycle.
// ----------------------------------------------------------------------------
module ohm_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ohm_pkg::KNOWN_W-1:0] a_i,
  input  logic [ohm_pkg::SUM_W-1:0]   b_i,
  output logic                       done_o,
  output logic [ohm_pkg::PROD_W-1:0]  prod_o
);
  import ohm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [KNOWN_W-1:0]   a_q;
  logic [PROD_W-1:0]    b_q;
  logic [PROD_W-1:0]    acc_q;
  logic                 last_step;

  assign last_step = cnt_q == MUL_CNT_W'(KNOWN_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= PROD_W'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (a_q[0]) begin
        acc_q <= acc_q + b_q;
      end
      a_q <= a_q >> 1;
      b_q <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### rtl/core/ohm_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider producing one quotient bit per cycle, with a sticky flag
// for quotient bits lost off the top of the quotient register.
// ----------------------------------------------------------------------------
module ohm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ohm_pkg::NUM_W-1:0] num_i,
  input  logic [ohm_pkg::DEN_W-1:0] den_i,
  output logic                      done_o,
  output logic [ohm_pkg::QUO_W-1:0] quo_o,
  output logic                      ovf_o
);
  import ohm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     den_q;
  logic [DEN_W-1:0]     rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic                 ovf_q;
  logic [DEN_W:0]       trial;
  logic [DEN_W+1:0]     diff;
  logic                 fits;
  logic                 last_step;

  assign trial     = {rem_q, num_q[NUM_W-1]};
  assign diff      = {1'b0, trial} - {2'b00, den_q};
  assign fits      = !diff[DEN_W+1];
  assign last_step = cnt_q == DIV_CNT_W'(NUM_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
      ovf_q <= ovf_q | quo_q[QUO_W-1];
      num_q <= num_q << 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

### rtl/core/ohm_e24.sv
// ----------------------------------------------------------------------------
// E24 search
// Walks the E24 values in ascending order, one candidate per cycle, and keeps
// the closest one to the fixed-point resistance. Ties keep the lower value.
// ----------------------------------------------------------------------------
module ohm_e24 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ohm_pkg::QUO_W-1:0] q_i,
  output logic                      done_o,
  output ohm_pkg::e24_res_t         res_o
);
  import ohm_pkg::*;

  logic              busy_q;
  logic              issue_q;
  logic              done_q;
  logic [IDX_W-1:0]  j_q;
  logic [MULT_W-1:0] m_q;
  logic              cand_vld_q;
  logic              cand_last_q;
  logic [OHMS_W-1:0] cand_v_q;
  logic [IDX_W-1:0]  cand_j_q;
  logic [MULT_W-1:0] cand_m_q;
  logic [QUO_W-1:0]  q_q;
  logic [QUO_W-1:0]  best_diff_q;
  logic [OHMS_W-1:0] best_v_q;
  logic [IDX_W-1:0]  best_j_q;
  logic [MULT_W-1:0] best_m_q;

  logic              last_issue;
  logic              last_mant;
  logic [OHMS_W-1:0] mant_ext;
  logic [OHMS_W-1:0] scale_ext;
  logic [OHMS_W-1:0] cand_v_d;
  logic [QUO_W-1:0]  cand_vq;
  logic              q_ge;
  logic [QUO_W-1:0]  diff;
  logic              better;
  logic              finish;

  assign last_mant  = j_q == IDX_W'(E24_COUNT - 1);
  assign last_issue = last_mant && (m_q == MULT_W'(DECADES - 1));
  assign mant_ext   = OHMS_W'(e24_mantissa(j_q));
  assign scale_ext  = OHMS_W'(decade_scale(m_q));
  assign cand_v_d   = mant_ext * scale_ext;

  assign cand_vq = QUO_W'({cand_v_q, FRAC_W'(0)});
  assign q_ge    = q_q >= cand_vq;
  assign diff    = q_ge ? (q_q - cand_vq) : (cand_vq - q_q);
  assign better  = diff < best_diff_q;
  assign finish  = cand_vld_q && (!q_ge || (q_q == cand_vq) || cand_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      issue_q    <= 1'b0;
      done_q     <= 1'b0;
      cand_vld_q <= 1'b0;
      j_q        <= '0;
      m_q        <= '0;
    end else begin
      done_q <= !start_i && busy_q && finish;
      if (start_i) begin
        busy_q     <= 1'b1;
        issue_q    <= 1'b1;
        cand_vld_q <= 1'b0;
        j_q        <= '0;
        m_q        <= '0;
      end else if (busy_q) begin
        if (finish) begin
          busy_q     <= 1'b0;
          issue_q    <= 1'b0;
          cand_vld_q <= 1'b0;
        end else begin
          cand_vld_q <= issue_q;
          if (issue_q) begin
            if (last_issue) begin
              issue_q <= 1'b0;
            end
            if (last_mant) begin
              j_q <= '0;
              m_q <= m_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q         <= q_i;
      best_diff_q <= '1;
    end else if (busy_q) begin
      if (issue_q) begin
        cand_v_q    <= cand_v_d;
        cand_j_q    <= j_q;
        cand_m_q    <= m_q;
        cand_last_q <= last_issue;
      end
      if (cand_vld_q && better) begin
        best_diff_q <= diff;
        best_v_q    <= cand_v_q;
        best_j_q    <= cand_j_q;
        best_m_q    <= cand_m_q;
      end
    end
  end

  assign done_o         = done_q;
  assign res_o.nearest  = best_v_q;
  assign res_o.first    = e24_tens(best_j_q);
  assign res_o.second   = e24_units(best_j_q);
  assign res_o.mult     = best_m_q;

endmodule

### dv/ohmmeter_e24_color_bands_tb.sv
// ----------------------------------------------------------------------------
// Ohmmeter with E24 colour bands: testbench
// Feeds converter samples through the stalling input channel. Between phases
// it rewrites the reference resistor and the reading length. It predicts
// every reading word independently: mean code, resistance, nearest E24 value
// and the colour bands. It then checks each word leaving the output channel
// against the oldest prediction. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module ohmmeter_e24_color_bands_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ohm_pkg::*;

  typedef struct packed {
    logic [ADC_BITS-1:0] average_code;
    logic [OHMS_W-1:0]   measured_ohms;
    logic [OHMS_W-1:0]   nearest_ohms;
    logic [BAND_W-1:0]   first_band;
    logic [BAND_W-1:0]   second_band;
    logic [MULT_W-1:0]   multiplier_band;
    logic                over_range;
  } reading_t;

  localparam logic [63:0] FULL_SCALE  = (64'd1 << ADC_BITS) - 64'd1;
  localparam logic [63:0] OHM_CEILING = 64'd100_000_000;
  localparam logic [24*7-1:0] E24_PACKED = {
    7'd91, 7'd82, 7'd75, 7'd68, 7'd62, 7'd56, 7'd51, 7'd47,
    7'd43, 7'd39, 7'd36, 7'd33, 7'd30, 7'd27, 7'd24, 7'd22,
    7'd20, 7'd18, 7'd16, 7'd15, 7'd13, 7'd12, 7'd11, 7'd10
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i = CFG_KNOWN_OHMS;
  logic [KNOWN_W-1:0]    cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [ADC_BITS-1:0]   adc_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [ADC_BITS-1:0]   average_code_o;
  logic [OHMS_W-1:0]     measured_ohms_o;
  logic [OHMS_W-1:0]     nearest_standard_ohms_o;
  logic [BAND_W-1:0]     first_band_o;
  logic [BAND_W-1:0]     second_band_o;
  logic [MULT_W-1:0]     multiplier_band_o;
  logic                  over_range_o;

  logic [ADC_BITS-1:0]   sample_queue[$];
  reading_t              expected_readings[$];
  logic [SUM_W-1:0]      meter_sum   = '0;
  logic [CNT_W-1:0]      meter_count = '0;
  logic [KNOWN_W-1:0]    meter_known = KNOWN_RESET;
  logic [CNT_W-1:0]      meter_spr   = SPR_RESET;
  logic                  in_fire     = 1'b0;
  bit                    gapless     = 1'b0;
  int                    mismatches    = 0;
  int                    readings_seen = 0;
  int                    samples_taken = 0;
  int                    reg_writes    = 0;
  int                    over_seen     = 0;

  ohmmeter_e24_color_bands u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .adc_sample_i           (adc_sample_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .average_code_o         (average_code_o),
    .measured_ohms_o        (measured_ohms_o),
    .nearest_standard_ohms_o(nearest_standard_ohms_o),
    .first_band_o           (first_band_o),
    .second_band_o          (second_band_o),
    .multiplier_band_o      (multiplier_band_o),
    .over_range_o           (over_range_o)
  );

  function automatic int samples_needed(input logic [CNT_W-1:0] spr);
    int n;
    n = int'(spr);
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    return n;
  endfunction

  function automatic reading_t predict_reading(input logic [SUM_W-1:0] sum,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic [KNOWN_W-1:0] known);
    reading_t    r;
    logic [63:0] span, q, ohms, best_diff, scale, digits, vq, diff;
    r = '0;
    span = 64'(cnt) * FULL_SCALE;
    r.average_code = ADC_BITS'((64'd2 * 64'(sum) + 64'(cnt)) / (64'd2 * 64'(cnt)));
    if (64'(sum) >= span) begin
      r.over_range = 1'b1;
      ohms = OHM_CEILING;
    end else begin
      q = (64'(known) * 64'(sum) * 64'd256) / (span - 64'(sum));
      ohms = (q + 64'd128) >> 8;
      if (ohms > OHM_CEILING) begin
        r.over_range = 1'b1;
        ohms = OHM_CEILING;
      end
    end
    if (r.over_range) q = OHM_CEILING << 8;
    r.measured_ohms = OHMS_W'(ohms);
    best_diff = '1;
    scale = 64'd1;
    for (int m = 0; m < DECADES; m++) begin
      for (int j = 0; j < E24_COUNT; j++) begin
        digits = 64'(E24_PACKED[j*7 +: 7]);
        vq = (digits * scale) << 8;
        diff = (q > vq) ? q - vq : vq - q;
        if (diff < best_diff) begin
          best_diff = diff;
          r.nearest_ohms = OHMS_W'(digits * scale);
          r.first_band = BAND_W'(digits / 64'd10);
          r.second_band = BAND_W'(digits % 64'd10);
          r.multiplier_band = MULT_W'(m);
        end
      end
      scale = scale * 64'd10;
    end
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("reading %0d: %s expected %0d, got %0d", readings_seen, field, want, got);
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [KNOWN_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  // Waits until every word has left and every reading has come back, then
  // lets the longest computation run out before any register is touched.
  task automatic settle();
    do @(posedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || expected_readings.size() != 0);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      if (!in_valid_i || in_fire) begin
        if (sample_queue.size() != 0 && (gapless || $urandom_range(99) >= 9)) begin
          in_valid_i   <= 1'b1;
          adc_sample_i <= sample_queue.pop_front();
        end else begin
          in_valid_i   <= 1'b0;
          adc_sample_i <= ADC_BITS'($urandom());
        end
      end
      out_stall_i <= !gapless && ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk_i) begin : monitor
    reading_t want;
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("reading %0d arrived with none expected, average code %0d",
                     readings_seen, average_code_o);
          end
        end else begin
          want = expected_readings.pop_front();
          if (want.over_range) over_seen++;
          compare_field("average_code", 32'(want.average_code), 32'(average_code_o));
          compare_field("measured_ohms", 32'(want.measured_ohms), 32'(measured_ohms_o));
          compare_field("nearest_standard_ohms", 32'(want.nearest_ohms),
                        32'(nearest_standard_ohms_o));
          compare_field("first_band", 32'(want.first_band), 32'(first_band_o));
          compare_field("second_band", 32'(want.second_band), 32'(second_band_o));
          compare_field("multiplier_band", 32'(want.multiplier_band),
                        32'(multiplier_band_o));
          compare_field("over_range", 32'(want.over_range), 32'(over_range_o));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_KNOWN_OHMS) begin
          meter_known = cfg_data_i;
        end else begin
          meter_spr = cfg_data_i[CNT_W-1:0];
        end
      end
      if (in_valid_i && !in_stall_o) begin
        samples_taken++;
        meter_sum = meter_sum + SUM_W'(adc_sample_i);
        meter_count = meter_count + 1'b1;
        if (int'(meter_count) >= samples_needed(meter_spr)) begin
          expected_readings.push_back(predict_reading(meter_sum, meter_count, meter_known));
          meter_sum = '0;
          meter_count = '0;
        end
      end
    end
  end

  initial begin
    int               len, readings, base, spread, v, extra, random_items, phase, spr;
    logic [KNOWN_W-1:0] data;
    random_items = 0;
    phase = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_KNOWN_OHMS, 20'd0);
    write_reg(CFG_SAMPLES_PER_READING, 20'd1);
    sample_queue.push_back(12'd2048);
    sample_queue.push_back(12'd4095);
    settle();

    write_reg(CFG_KNOWN_OHMS, 20'd1000000);
    write_reg(CFG_SAMPLES_PER_READING, 20'd0);
    sample_queue.push_back(12'd0);
    sample_queue.push_back(12'd4095);
    sample_queue.push_back(12'd4094);
    sample_queue.push_back(12'd1);
    sample_queue.push_back(12'd2048);
    settle();

    write_reg(CFG_KNOWN_OHMS, 20'd1);
    write_reg(CFG_SAMPLES_PER_READING, 20'd1);
    sample_queue.push_back(12'd1);
    sample_queue.push_back(12'd4094);
    settle();

    // Exactly halfway between two E24 values; the lower one must win.
    write_reg(CFG_KNOWN_OHMS, 20'd35);
    sample_queue.push_back(12'd3276);
    settle();
    write_reg(CFG_KNOWN_OHMS, 20'd4775);
    sample_queue.push_back(12'd2730);
    settle();

    write_reg(CFG_KNOWN_OHMS, KNOWN_RESET);
    write_reg(CFG_SAMPLES_PER_READING, 20'd2);
    sample_queue.push_back(12'd0);
    sample_queue.push_back(12'd1);
    sample_queue.push_back(12'd4095);
    sample_queue.push_back(12'd4094);
    settle();

    write_reg(CFG_SAMPLES_PER_READING, 20'd1024);
    sample_queue.push_back(12'd1000);
    sample_queue.push_back(12'd3000);
    settle();
    write_reg(CFG_SAMPLES_PER_READING, 20'd1);
    sample_queue.push_back(12'd2000);
    settle();

    write_reg(CFG_KNOWN_OHMS, 20'hFFFFF);
    write_reg(CFG_SAMPLES_PER_READING, 20'd3);
    sample_queue.push_back(12'd4095);
    sample_queue.push_back(12'd4095);
    sample_queue.push_back(12'd4094);
    settle();

    while (random_items < 1300) begin
      gapless = (phase >= 5 && phase < 12);
      if (phase == 8) begin
        write_reg(CFG_SAMPLES_PER_READING, 20'h007FF);
        for (int k = 0; k < MAX_SAMPLES; k++) begin
          sample_queue.push_back(ADC_BITS'($urandom_range(3900, 4095)));
        end
        random_items += MAX_SAMPLES;
      end else begin
        case ($urandom_range(9))
          0:       write_reg(CFG_KNOWN_OHMS, KNOWN_W'($urandom()));
          1:       write_reg(CFG_KNOWN_OHMS, 20'd0);
          2, 3:    write_reg(CFG_KNOWN_OHMS, KNOWN_W'($urandom_range(1, 200)));
          4, 5:    write_reg(CFG_KNOWN_OHMS, KNOWN_W'($urandom_range(200, 20000)));
          6, 7:    write_reg(CFG_KNOWN_OHMS, KNOWN_W'($urandom_range(20000, 1000000)));
          default: ;
        endcase
        case ($urandom_range(9))
          0:             spr = 0;
          1, 2, 3, 4, 5: spr = int'($urandom_range(1, 6));
          6, 7, 8:       spr = int'($urandom_range(7, 32));
          default:       spr = -1;
        endcase
        if (spr < 0 && samples_needed(meter_spr) > 32) spr = int'($urandom_range(1, 6));
        if (spr >= 0) begin
          data = KNOWN_W'(spr);
          if ($urandom_range(7) == 0) data = data | (KNOWN_W'($urandom_range(1, 511)) << CNT_W);
          write_reg(CFG_SAMPLES_PER_READING, data);
        end
        len = samples_needed(meter_spr);
        readings = int'($urandom_range(2, 8));
        for (int r = 0; r < readings; r++) begin
          case ($urandom_range(7))
            0:       base = int'($urandom_range(0, 40));
            1:       base = int'($urandom_range(4050, 4095));
            2:       base = 4095;
            default: base = int'($urandom_range(0, 4095));
          endcase
          spread = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 12));
          for (int k = 0; k < len; k++) begin
            v = base + int'($urandom_range(2 * spread)) - spread;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            sample_queue.push_back(ADC_BITS'(v));
          end
          random_items += len;
        end
        if (len > 1 && $urandom_range(4) == 0) begin
          extra = int'($urandom_range(1, len - 1));
          for (int k = 0; k < extra; k++) begin
            sample_queue.push_back(ADC_BITS'($urandom()));
          end
          random_items += extra;
        end
      end
      settle();
      phase++;
    end

    if (expected_readings.size() != 0) begin
      mismatches += expected_readings.size();
      $display("%0d readings never arrived", expected_readings.size());
    end
    $display("Covered %0d samples and %0d readings, %0d of them over range",
             samples_taken, readings_seen, over_seen);
    $display("Register writes: %0d, spread over %0d random phases", reg_writes, phase);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timed out waiting for the block");
    $display("Mismatches found");
    $finish;
  end

endmodule
